/* rtl/qpr_pkg.sv */
`timescale 1ns / 1ps
// qpr_pkg: widths, data types, angle table and helper functions for the
// quaternion to pitch/roll core. No dependencies.
package qpr_pkg;

  localparam int Q_W     = 16;  // quaternion component width
  localparam int P_W     = 32;  // 16x16 product width
  localparam int WIDE_W  = 36;  // matrix entry before the cut to Q21
  localparam int M_W     = 27;  // matrix entry, Q21
  localparam int SQ_W    = 52;  // m22^2 + m21^2
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int THR_W   = 15;
  localparam int THR_SH  = 7;   // threshold Q14 to Q21
  localparam int CX_W    = 30;  // cordic x/y width
  localparam int ANG_W   = 35;  // cordic angle, 2^31 = pi
  localparam int ANG_OUT_W = 16;
  localparam int TAB_LEN = 24;

  localparam logic signed [WIDE_W-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [ANG_W-1:0]  QUARTER = 35'sd1073741824;
  localparam logic signed [ANG_W-1:0]  HALF_LSB = 35'sd32768;
  localparam logic signed [ANG_W-1:0]  OUT_MAX = 35'sd32767;
  localparam logic signed [ANG_W-1:0]  OUT_MIN = -35'sd32768;

  // atan(2^-k) in units of pi/2^31
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    35'sd536870912, 35'sd316933406, 35'sd167458907, 35'sd85004756,
    35'sd42667331,  35'sd21354465,  35'sd10679838,  35'sd5340245,
    35'sd2670163,   35'sd1335087,   35'sd667544,    35'sd333772,
    35'sd166886,    35'sd83443,     35'sd41722,     35'sd20861,
    35'sd10430,     35'sd5215,      35'sd2608,      35'sd1304,
    35'sd652,       35'sd326,       35'sd163,       35'sd81
  };

  typedef struct packed {
    logic signed [M_W-1:0] m01;
    logic signed [M_W-1:0] m11;
    logic signed [M_W-1:0] m20;
    logic signed [M_W-1:0] m21;
    logic signed [M_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } rot_t;

  typedef struct packed {
    logic lock;
    logic neg;
    logic zero_p;
    logic zero_r;
  } flag_t;

  typedef struct packed {
    logic signed [ANG_OUT_W-1:0] pitch;
    logic signed [ANG_OUT_W-1:0] roll;
    logic                        lock;
  } res_t;

  // left half plane points are turned by a quarter turn first
  function automatic rot_t pre_rotate(input logic signed [CX_W-1:0] y,
                                      input logic signed [CX_W-1:0] x);
    rot_t r;
    r.x   = x;
    r.y   = y;
    r.ang = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x   = y;
        r.y   = -x;
        r.ang = QUARTER;
      end else begin
        r.x   = -y;
        r.y   = x;
        r.ang = -QUARTER;
      end
    end
    return r;
  endfunction

  function automatic logic signed [ANG_OUT_W-1:0] to_b16(
      input logic signed [ANG_W-1:0] ang, input logic zero, input logic neg);
    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W-1:0] s;
    logic signed [ANG_OUT_W-1:0] r;
    a = zero ? '0 : ang;
    if (neg) begin
      a = -a;
    end
    s = (a + HALF_LSB) >>> 16;
    if (s > OUT_MAX) begin
      r = OUT_MAX[ANG_OUT_W-1:0];
    end else if (s < OUT_MIN) begin
      r = OUT_MIN[ANG_OUT_W-1:0];
    end else begin
      r = s[ANG_OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/qpr_if.sv */
`timescale 1ns / 1ps
// qpr channel interfaces: quaternion input, pitch/roll result and
// threshold write channel. Depends on qpr_pkg.
interface qpr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qpr_pkg::Q_W-1:0]     quat_w;
  logic signed [qpr_pkg::Q_W-1:0]     quat_x;
  logic signed [qpr_pkg::Q_W-1:0]     quat_y;
  logic signed [qpr_pkg::Q_W-1:0]     quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qpr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qpr_pkg::ANG_OUT_W-1:0] pitch_angle;
  logic signed [qpr_pkg::ANG_OUT_W-1:0] roll_angle;
  logic                                 gimbal_lock;
  modport source (output valid, pitch_angle, roll_angle, gimbal_lock, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, gimbal_lock, output ready);
endinterface

interface qpr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [qpr_pkg::THR_W-1:0]      lock_threshold;
  modport source (output valid, lock_threshold, input ready);
  modport sink   (input valid, lock_threshold, output ready);
endinterface

/* rtl/qpr_sqrt_cell.sv */
`timescale 1ns / 1ps
// qpr_sqrt_cell: one root bit of the digit-by-digit integer square root,
// carrying the matrix entries alongside. Depends on qpr_pkg.
module qpr_sqrt_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qpr_pkg::REM_W-1:0]     rem_i,
  input  logic [qpr_pkg::ROOT_W-1:0]    root_i,
  input  logic [qpr_pkg::SQ_W-1:0]      rad_i,
  input  qpr_pkg::mat_t                 mat_i,
  output logic [qpr_pkg::REM_W-1:0]     rem_o,
  output logic [qpr_pkg::ROOT_W-1:0]    root_o,
  output logic [qpr_pkg::SQ_W-1:0]      rad_o,
  output qpr_pkg::mat_t                 mat_o
);
  logic [qpr_pkg::REM_W-1:0]  rem_sh;
  logic [qpr_pkg::REM_W-1:0]  trial;
  logic                       ge;
  logic [qpr_pkg::REM_W-1:0]  rem_nxt;
  logic [qpr_pkg::ROOT_W-1:0] root_nxt;
  logic [qpr_pkg::REM_W-1:0]  rem_r;
  logic [qpr_pkg::ROOT_W-1:0] root_r;
  logic [qpr_pkg::SQ_W-1:0]   rad_r;
  qpr_pkg::mat_t              mat_r;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh   = {rem_i[qpr_pkg::REM_W-3:0], rad_i[qpr_pkg::SQ_W-1 -: 2]};
    trial    = qpr_pkg::REM_W'({root_i, 2'b01});
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[qpr_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_i[qpr_pkg::SQ_W-3:0], 2'b00};
      mat_r  <= mat_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign mat_o  = mat_r;
endmodule

/* rtl/qpr_cordic_cell.sv */
`timescale 1ns / 1ps
// qpr_cordic_cell: one vectoring cordic micro-rotation by atan(2^-SHIFT).
// Depends on qpr_pkg.
module qpr_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  qpr_pkg::rot_t rot_i,
  output qpr_pkg::rot_t rot_o
);
  logic signed [qpr_pkg::CX_W-1:0] xs;
  logic signed [qpr_pkg::CX_W-1:0] ys;
  qpr_pkg::rot_t                   rot_nxt;
  qpr_pkg::rot_t                   rot_r;

  always_comb begin
    xs      = rot_i.x >>> SHIFT;
    ys      = rot_i.y >>> SHIFT;
    rot_nxt = rot_i;
    if (rot_i.y > 0) begin
      rot_nxt.x   = rot_i.x + ys;
      rot_nxt.y   = rot_i.y - xs;
      rot_nxt.ang = rot_i.ang + qpr_pkg::ATAN_TAB[SHIFT];
    end else begin
      rot_nxt.x   = rot_i.x - ys;
      rot_nxt.y   = rot_i.y + xs;
      rot_nxt.ang = rot_i.ang - qpr_pkg::ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot_o = rot_r;
endmodule

/* rtl/quaternion_to_pitch_roll_core.sv */
`timescale 1ns / 1ps
// quaternion_to_pitch_roll_core: from the input transfer to out valid, the data passes
// 4 product/matrix stages, 26 square-root cells, one pre-rotation stage,
// CORDIC_STAGES cordic cells, the rounding stage and the output buffer.
// Throughput one item per cycle; the pipeline stalls only when both output
// buffer entries are taken. Synchronous active-low reset clears valids and
// sets lock_threshold to 1.
module quaternion_to_pitch_roll_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qpr_in_if.sink    in_chan,
  qpr_out_if.source out_chan,
  qpr_cfg_if.sink   cfg_chan
);
  localparam int NR = qpr_pkg::ROOT_W;

  logic                             en;
  logic [qpr_pkg::THR_W-1:0]        thr_r;

  // products
  logic                             v1_r;
  logic signed [qpr_pkg::P_W-1:0]   xy_r, wz_r, xx_r, zz_r, xz_r, wy_r, yz_r, wx_r, yy_r;
  // matrix entries
  logic                             v2_r;
  qpr_pkg::mat_t                    mat2_r;
  qpr_pkg::mat_t                    mat2_nxt;
  // squares
  logic                             v3_r;
  qpr_pkg::mat_t                    mat3_r;
  logic signed [2*qpr_pkg::M_W-1:0] sq22_r, sq21_r;
  // square-root chain
  logic [NR:0]                      vs_r;
  logic [qpr_pkg::REM_W-1:0]        rem_w  [NR+1];
  logic [qpr_pkg::ROOT_W-1:0]       root_w [NR+1];
  logic [qpr_pkg::SQ_W-1:0]         rad_w  [NR+1];
  qpr_pkg::mat_t                    mat_w  [NR+1];
  logic [qpr_pkg::SQ_W-1:0]         sum_r;
  qpr_pkg::mat_t                    mat4_r;
  // cordic chains
  logic [CORDIC_STAGES:0]           vc_r;
  qpr_pkg::rot_t                    prot_w [CORDIC_STAGES+1];
  qpr_pkg::rot_t                    rrot_w [CORDIC_STAGES+1];
  qpr_pkg::flag_t                   flag_r [CORDIC_STAGES+1];
  qpr_pkg::rot_t                    prot0_r, rrot0_r;
  qpr_pkg::rot_t                    prot_nxt, rrot_nxt;
  qpr_pkg::flag_t                   flag_nxt;
  logic signed [qpr_pkg::CX_W-1:0]  ry, rx, root_x;
  qpr_pkg::mat_t                    mq;
  // rounding stage and output buffer
  logic                             vf_r;
  qpr_pkg::res_t                    fin_r;
  qpr_pkg::res_t                    e0_r, e1_r;
  logic [1:0]                       cnt_r;
  logic                             push, pop;

  function automatic logic signed [qpr_pkg::M_W-1:0] cut7(
      input logic signed [qpr_pkg::WIDE_W-1:0] v);
    logic signed [qpr_pkg::WIDE_W-1:0] s;
    s = v >>> 7;
    return s[qpr_pkg::M_W-1:0];
  endfunction

  assign pop  = (cnt_r != 2'd0) && out_chan.ready;
  assign en   = (cnt_r != 2'd2) || out_chan.ready;
  assign push = en && vf_r;

  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qpr_pkg::THR_W'(1);
    end else if (cfg_chan.valid) begin
      thr_r <= cfg_chan.lock_threshold;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vs_r <= '0;
      vc_r <= '0;
      vf_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vs_r <= {vs_r[NR-1:0], v3_r};
      vc_r <= {vc_r[CORDIC_STAGES-1:0], vs_r[NR]};
      vf_r <= vc_r[CORDIC_STAGES];
    end
  end

  always_comb begin
    mat2_nxt.m01 = cut7((qpr_pkg::WIDE_W'(xy_r) - qpr_pkg::WIDE_W'(wz_r)) <<< 1);
    mat2_nxt.m11 = cut7(qpr_pkg::ONE_Q28
                        - ((qpr_pkg::WIDE_W'(xx_r) + qpr_pkg::WIDE_W'(zz_r)) <<< 1));
    mat2_nxt.m20 = cut7((qpr_pkg::WIDE_W'(xz_r) - qpr_pkg::WIDE_W'(wy_r)) <<< 1);
    mat2_nxt.m21 = cut7((qpr_pkg::WIDE_W'(yz_r) + qpr_pkg::WIDE_W'(wx_r)) <<< 1);
    mat2_nxt.m22 = cut7(qpr_pkg::ONE_Q28
                        - ((qpr_pkg::WIDE_W'(xx_r) + qpr_pkg::WIDE_W'(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy_r   <= in_chan.quat_x * in_chan.quat_y;
      wz_r   <= in_chan.quat_w * in_chan.quat_z;
      xx_r   <= in_chan.quat_x * in_chan.quat_x;
      zz_r   <= in_chan.quat_z * in_chan.quat_z;
      xz_r   <= in_chan.quat_x * in_chan.quat_z;
      wy_r   <= in_chan.quat_w * in_chan.quat_y;
      yz_r   <= in_chan.quat_y * in_chan.quat_z;
      wx_r   <= in_chan.quat_w * in_chan.quat_x;
      yy_r   <= in_chan.quat_y * in_chan.quat_y;
      mat2_r <= mat2_nxt;
      mat3_r <= mat2_r;
      sq22_r <= mat2_r.m22 * mat2_r.m22;
      sq21_r <= mat2_r.m21 * mat2_r.m21;
      sum_r  <= sq22_r[qpr_pkg::SQ_W-1:0] + sq21_r[qpr_pkg::SQ_W-1:0];
      mat4_r <= mat3_r;
    end
  end

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = sum_r;
  assign mat_w[0]  = mat4_r;

  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    qpr_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rad_i  (rad_w[i]),
      .mat_i  (mat_w[i]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1]),
      .rad_o  (rad_w[i+1]),
      .mat_o  (mat_w[i+1])
    );
  end

  // lock test, roll operand choice and quarter-turn pre-rotation
  always_comb begin
    mq            = mat_w[NR];
    root_x        = qpr_pkg::CX_W'({1'b0, root_w[NR]});
    flag_nxt.lock = !(root_w[NR] > qpr_pkg::ROOT_W'({thr_r, {qpr_pkg::THR_SH{1'b0}}}));
    flag_nxt.neg  = flag_nxt.lock && !(mq.m20 > 0);
    if (flag_nxt.lock) begin
      ry = -qpr_pkg::CX_W'(mq.m01);
      rx = qpr_pkg::CX_W'(mq.m11);
    end else begin
      ry = qpr_pkg::CX_W'(mq.m21);
      rx = qpr_pkg::CX_W'(mq.m22);
    end
    flag_nxt.zero_p = (mq.m20 == '0) && (root_w[NR] == '0);
    flag_nxt.zero_r = (ry == '0) && (rx == '0);
    prot_nxt = qpr_pkg::pre_rotate(-qpr_pkg::CX_W'(mq.m20), root_x);
    rrot_nxt = qpr_pkg::pre_rotate(ry, rx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prot0_r   <= prot_nxt;
      rrot0_r   <= rrot_nxt;
      flag_r[0] <= flag_nxt;
    end
  end

  assign prot_w[0] = prot0_r;
  assign rrot_w[0] = rrot0_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qpr_cordic_cell #(.SHIFT(k)) u_pitch (
      .clk   (clk),
      .en    (en),
      .rot_i (prot_w[k]),
      .rot_o (prot_w[k+1])
    );
    qpr_cordic_cell #(.SHIFT(k)) u_roll (
      .clk   (clk),
      .en    (en),
      .rot_i (rrot_w[k]),
      .rot_o (rrot_w[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        flag_r[k+1] <= flag_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r.pitch <= qpr_pkg::to_b16(prot_w[CORDIC_STAGES].ang,
                                     flag_r[CORDIC_STAGES].zero_p, 1'b0);
      fin_r.roll  <= qpr_pkg::to_b16(rrot_w[CORDIC_STAGES].ang,
                                     flag_r[CORDIC_STAGES].zero_r,
                                     flag_r[CORDIC_STAGES].neg);
      fin_r.lock  <= flag_r[CORDIC_STAGES].lock;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0_r <= (cnt_r == 2'd2) ? e1_r : fin_r;
    end else if (cnt_r == 2'd0) begin
      e0_r <= fin_r;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      e1_r <= fin_r;
    end
  end

  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.pitch_angle = e0_r.pitch;
  assign out_chan.roll_angle  = e0_r.roll;
  assign out_chan.gimbal_lock = e0_r.lock;
endmodule

/* rtl/qpr_checker.sv */
`timescale 1ns / 1ps
// qpr_core_props: port-level checks on quaternion_to_pitch_roll_core, bound to
// the top level below. Depends on qpr_pkg and the qpr channel interfaces.
module qpr_core_props (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [qpr_pkg::ANG_OUT_W-1:0]  out_pitch,
  input logic signed [qpr_pkg::ANG_OUT_W-1:0]  out_roll,
  input logic                                  out_lock,
  input logic                                  cfg_ready
);
  logic [7:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  // no result without an accepted item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 8'd0))
    else $error("result shown with no item outstanding");

  // a waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch)
                                && $stable(out_roll) && $stable(out_lock))
    else $error("stalled result changed");

  // an open output side never throttles the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("threshold write refused");
endmodule

bind quaternion_to_pitch_roll_core qpr_core_props u_qpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pitch (out_chan.pitch_angle),
  .out_roll  (out_chan.roll_angle),
  .out_lock  (out_chan.gimbal_lock),
  .cfg_ready (cfg_chan.ready)
);

/* dv/qpr_checker.sv */
`timescale 1ns / 1ps
// qpr_checker: predicts pitch, roll and lock flag for every quaternion transfer
// and compares them with the result channel. Depends on qpr_pkg and qpr_if.
module qpr_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qpr_in_if         in_mon,
  qpr_out_if        out_mon,
  qpr_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending_count
);

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               lock;
  } angles_t;

  angles_t                    angle_queue[$];
  logic [qpr_pkg::THR_W-1:0]  thr_shadow;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint a, t, xs, ys;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; a = 64'sd1073741824;
      end else begin
        x = -y; y = t; a = -64'sd1073741824;
      end
    end
    for (int k = 0; k < CORDIC_STAGES && k < qpr_pkg::TAB_LEN; k++) begin
      xs = floor_shr(x, k);
      ys = floor_shr(y, k);
      if (y > 0) begin
        x += ys; y -= xs; a += longint'(qpr_pkg::ATAN_TAB[k]);
      end else begin
        x -= ys; y += xs; a -= longint'(qpr_pkg::ATAN_TAB[k]);
      end
    end
    return a;
  endfunction

  function automatic logic signed [15:0] to_angle16(longint a);
    longint r;
    r = floor_shr(a + 32768, 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(longint w, longint x, longint y, longint z,
                                             logic [qpr_pkg::THR_W-1:0] thr);
    angles_t res;
    longint m01, m11, m20, m21, m22, ip, p, r;
    longint unsigned sq;
    longint one;
    one = 64'sd1 << 28;
    m01 = floor_shr(2 * (x * y - w * z), 7);
    m11 = floor_shr(one - 2 * (x * x + z * z), 7);
    m20 = floor_shr(2 * (x * z - w * y), 7);
    m21 = floor_shr(2 * (y * z + w * x), 7);
    m22 = floor_shr(one - 2 * (x * x + y * y), 7);
    sq = longint'(m22 * m22) + longint'(m21 * m21);
    ip = int_sqrt(sq);
    p = vector_angle(-m20, ip);
    res.lock = !(ip > (longint'(thr) << 7));
    if (!res.lock) begin
      r = vector_angle(m21, m22);
    end else begin
      r = vector_angle(-m01, m11);
      if (!(m20 > 0)) r = -r;
    end
    res.pitch = to_angle16(p);
    res.roll = to_angle16(r);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      thr_shadow <= qpr_pkg::THR_W'(1);
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) thr_shadow <= cfg_mon.lock_threshold;
      if (in_mon.valid && in_mon.ready)
        angle_queue.push_back(predict_angles(in_mon.quat_w, in_mon.quat_x,
                                             in_mon.quat_y, in_mon.quat_z, thr_shadow));
      if (out_mon.valid && out_mon.ready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected result, queue size", 0, 1);
        end else begin
          e = angle_queue.pop_front();
          if (out_mon.pitch_angle !== e.pitch)
            report_mismatch("pitch_angle", out_mon.pitch_angle, e.pitch);
          if (out_mon.roll_angle !== e.roll)
            report_mismatch("roll_angle", out_mon.roll_angle, e.roll);
          if (out_mon.gimbal_lock !== e.lock)
            report_mismatch("gimbal_lock", out_mon.gimbal_lock, e.lock);
        end
      end
    end
    pending_count = angle_queue.size();
  end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: drives quaternion bursts and threshold writes into the pitch/roll
// core and gives the verdict. Depends on qpr_pkg, qpr_if and qpr_checker.
module tb_top;

  localparam int STAGES = 16;
  localparam int DRAIN = STAGES + 60;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count;
  int   burst_left = 0;
  logic stall_mode = 0;

  qpr_in_if  in_chan();
  qpr_out_if out_chan();
  qpr_cfg_if cfg_chan();

  always #2 clk = ~clk;

  quaternion_to_pitch_roll_core #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  qpr_checker #(.CORDIC_STAGES(STAGES)) i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan), .cfg_mon(cfg_chan),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver stall pattern: long phases with and without back pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    out_chan.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.quat_w <= w;
    in_chan.quat_x <= x;
    in_chan.quat_y <= y;
    in_chan.quat_z <= z;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_threshold(logic [qpr_pkg::THR_W-1:0] thr);
    drain_pipe();
    cfg_chan.valid <= 1'b1;
    cfg_chan.lock_threshold <= thr;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // half with |w|+|x|+|y|+|z| = 1, the rest gimbal-lock poses and raw noise
  task automatic send_random();
    int c, s, a, b, k, rot;
    logic [15:0] v[4];
    logic [15:0] t;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      a = $urandom_range(0, 16384);
      b = $urandom_range(0, 16384 - a);
      c = $urandom_range(0, 16384 - a - b);
      s = 16384 - a - b - c;
      v[0] = 16'($urandom_range(0, 1) ? -a : a);
      v[1] = 16'($urandom_range(0, 1) ? -b : b);
      v[2] = 16'($urandom_range(0, 1) ? -c : c);
      v[3] = 16'($urandom_range(0, 1) ? -s : s);
      // random rotation of the component order
      rot = $urandom_range(0, 3);
      for (int j = 0; j < rot; j++) begin
        t = v[0];
        v[0] = v[1];
        v[1] = v[2];
        v[2] = v[3];
        v[3] = t;
      end
    end else if (k < 8) begin
      // pitch near +-90: w = +-y, x = +-z roughly, small jitter
      a = $urandom_range(0, 11585);
      b = $urandom_range(0, 11585);
      c = $urandom_range(0, 40);
      v[0] = 16'(a);
      v[2] = 16'(($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, c)) - c / 2);
      v[1] = 16'(b);
      v[3] = 16'(($urandom_range(0, 1) ? b : -b) + int'($urandom_range(0, c)) - c / 2);
    end else begin
      foreach (v[i]) v[i] = 16'($urandom());
    end
    send_quat(v[0], v[1], v[2], v[3]);
  endtask

  initial begin
    int n;
    logic [qpr_pkg::THR_W-1:0] thr_list[5] = '{15'd0, 15'd16384, 15'd200, 15'd32767, 15'd1};
    in_chan.valid = 1'b0;
    in_chan.quat_w = '0; in_chan.quat_x = '0; in_chan.quat_y = '0; in_chan.quat_z = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.lock_threshold = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: identity, extremes, gimbal lock, plus pi, origin
    send_quat(16'sd16384, 16'd0, 16'd0, 16'd0);
    send_quat(16'd0, 16'd0, 16'd0, 16'd0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_quat(16'd0, 16'sd16384, 16'd0, 16'd0);
    send_quat(16'd0, 16'd0, 16'sd16384, 16'd0);
    send_quat(16'd0, 16'd0, 16'd0, 16'sd16384);
    send_quat(16'sd11585, 16'd0, 16'sd11585, 16'd0);
    send_quat(16'sd11585, 16'd0, -16'sd11585, 16'd0);
    send_quat(16'sd11585, 16'sd3000, 16'sd11585, 16'sd3000);
    send_quat(16'sd11585, 16'sd3000, -16'sd11585, -16'sd3000);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'h8000, 16'd0, 16'd0, 16'd0);
    send_quat(16'd0, 16'h8000, 16'd0, 16'h7fff);
    drain_pipe();

    n = 0;
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      repeat (370) begin
        send_random();
        n++;
        if (n == 900) drain_pipe();
      end
    end
    drain_pipe();
    if (fail_count == 0) begin
      $display("quaternion_to_pitch_roll_core: match");
    end else begin
      $display("quaternion_to_pitch_roll_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("quaternion_to_pitch_roll_core: mismatch");
    $finish;
  end
endmodule
